// ===== sv/stifl_pkg.sv =====
`default_nettype none

package stifl_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;

    localparam int TIME_W  = 31;
    localparam int TOL_W   = 20;
    localparam int COUNT_W = 13;

    localparam logic [TOL_W-1:0] TOL_RESET = 20'd100;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_REJECT = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;
    localparam logic [1:0] STAT_LOOKUP = 2'd3;

endpackage

`default_nettype wire

// ===== sv/stifl_ram.sv =====
`default_nettype none

module stifl_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/sorted_time_index_floor_lookup.sv =====
// Ordered table of key-frame times (microseconds) with floor lookup. Each input
// item carries a command in s_tuser (append, lookup, clear) and a signed time in
// s_tdata, and gives exactly one result item. Append, clear and lookups that need
// no search (empty table or query not positive) finish straight from idle, with
// the result registered when they are taken. A search halves the range once per
// cycle through the table RAM's registered read, then reads the floor entry. One
// item is in flight at a time; s_tready is high in idle while the result
// register is free or being taken. The table RAM holds no reset value: only
// entries below the count are ever read. tolerance_us is written by cfg_wr_en /
// cfg_wr_data and resets to 100.
`default_nettype none

module sorted_time_index_floor_lookup
    import stifl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              cfg_wr_en,
    input  wire logic [TOL_W-1:0]  cfg_wr_data,   // tolerance_us

    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_tdata,       // [31:0] time_value (signed)
    input  wire logic [1:0]        s_tuser,       // [1:0] command

    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [47:0]       m_tdata,       // [30:0] found_time, [43:31] entry_count
    output logic      [1:0]        m_tuser        // [1:0] status
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINAL
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TIME_W-1:0]   last_reg, last_next;
    logic [TOL_W-1:0]    tol_reg, tol_next;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [CNT_W-1:0]    mid_reg, mid_next;
    logic [TIME_W-1:0]   query_reg, query_next;
    logic                out_valid_reg, out_valid_next;
    logic [TIME_W-1:0]   found_reg, found_next;
    logic [1:0]          status_reg, status_next;
    logic [COUNT_W-1:0]  ocount_reg, ocount_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [TIME_W-1:0]   ram_rdata;

    logic                accept;
    logic signed [31:0]  t_in;
    logic [32:0]         limit;
    logic                not_later;
    logic                full;
    logic                le;
    logic [CNT_W-1:0]    lo_step, hi_step, floor_idx;
    logic [CNT_W:0]      sum_step;
    logic [CNT_W:0]      sum_first;
    logic [CNT_W+COUNT_W-1:0] count_ext;
    logic [CNT_W+COUNT_W-1:0] count_ext_next;

    stifl_ram #(
        .WIDTH (TIME_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (t_in[TIME_W-1:0]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign t_in     = s_tdata;

    // no-wrap sum: times up to last plus tolerance are rejected, even for a large tolerance
    assign limit     = {2'b00, last_reg} + {13'd0, tol_reg};
    assign not_later = (count_reg != '0) && ({1'b0, t_in} <= limit);
    assign full      = count_reg >= CNT_W'(TABLE_DEPTH);

    // search step on the entry just read at mid
    assign le        = ram_rdata <= query_reg;
    assign lo_step   = le ? (mid_reg + CNT_W'(1)) : lo_reg;
    assign hi_step   = le ? hi_reg : mid_reg;
    assign sum_step  = {1'b0, lo_step} + {1'b0, hi_step};
    assign floor_idx = (lo_step == '0) ? '0 : (lo_step - CNT_W'(1));
    assign sum_first = {1'b0, count_reg};

    assign count_ext = {{COUNT_W{1'b0}}, count_reg};

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        tol_next       = cfg_wr_en ? cfg_wr_data : tol_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        query_next     = query_reg;
        out_valid_next = out_valid_reg && !m_tready;
        found_next     = found_reg;
        status_next    = status_reg;
        ocount_next    = ocount_reg;
        ram_we         = 1'b0;
        ram_raddr      = mid_reg[ADDR_W-1:0];
        count_ext_next = count_ext;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    found_next = '0;
                    case (s_tuser)
                        CMD_APPEND: begin
                            if (t_in[31] || not_later) begin
                                status_next = STAT_REJECT;
                            end else if (full) begin
                                status_next = STAT_FULL;
                            end else begin
                                status_next = STAT_OK;
                                ram_we      = 1'b1;
                                last_next   = t_in[TIME_W-1:0];
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_LOOKUP: begin
                            status_next = STAT_LOOKUP;
                            if (!(count_reg == '0 || t_in[31] || t_in == 32'sd0)) begin
                                lo_next    = '0;
                                hi_next    = count_reg;
                                mid_next   = sum_first[CNT_W:1];
                                ram_raddr  = sum_first[ADDR_W:1];
                                query_next = t_in[TIME_W-1:0];
                                state_next = S_SEARCH;
                            end
                        end
                        CMD_CLEAR: begin
                            status_next = STAT_OK;
                            count_next  = '0;
                            last_next   = '0;
                        end
                        default: begin
                            status_next = STAT_REJECT;
                        end
                    endcase
                    count_ext_next = {{COUNT_W{1'b0}}, count_next};
                    ocount_next    = count_ext_next[COUNT_W-1:0];
                    if (state_next == S_IDLE) begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            S_SEARCH: begin
                lo_next = lo_step;
                hi_next = hi_step;
                if (lo_step < hi_step) begin
                    mid_next  = sum_step[CNT_W:1];
                    ram_raddr = sum_step[ADDR_W:1];
                end else begin
                    ram_raddr  = floor_idx[ADDR_W-1:0];
                    state_next = S_FINAL;
                end
            end
            S_FINAL: begin
                found_next     = ram_rdata;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            last_reg      <= '0;
            tol_reg       <= TOL_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            tol_reg       <= tol_next;
            out_valid_reg <= out_valid_next;
        end
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        query_reg  <= query_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        ocount_reg <= ocount_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, ocount_reg, found_reg};
    assign m_tuser  = status_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_search_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SEARCH) |-> (lo_reg < hi_reg) && (hi_reg <= count_reg)
            && (mid_reg >= lo_reg) && (mid_reg < hi_reg))
        else $error("search range out of order");

    a_final_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINAL) |=> out_valid_reg && (status_reg == STAT_LOOKUP)
            && (state_reg == S_IDLE))
        else $error("search end gave no lookup result");

    a_no_write_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !ram_we && $stable(count_reg))
        else $error("table changed during search");

endmodule

`default_nettype wire
